@@ rtl/owm_pkg.sv @@
// shared types and constants for the one-wire bus master
package owm_pkg;

	localparam int unsigned US_W = 9;
	localparam int unsigned CPM_W = 8;

	localparam logic [CPM_W-1:0] CPM_RESET = 8'd168;

	localparam logic [US_W-1:0] RESET_LOW_US = 9'd480;
	localparam logic [US_W-1:0] PRESENCE_SAMPLE_US = 9'd80;
	localparam logic [US_W-1:0] RESET_RECOVERY_US = 9'd400;
	localparam logic [US_W-1:0] SLOT_US = 9'd60;
	localparam logic [US_W-1:0] WR_SHORT_US = 9'd1;
	localparam logic [US_W-1:0] RD_LOW_US = 9'd2;

	localparam logic [1:0] KIND_TICK = 2'd0;
	localparam logic [1:0] KIND_RESET = 2'd1;
	localparam logic [1:0] KIND_WRITE = 2'd2;
	localparam logic [1:0] KIND_READ = 2'd3;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] write_byte;
		logic       line_level;
	} owm_item_t;

	typedef struct packed {
		logic       rejected;
		logic [7:0] read_byte;
		logic       presence;
		logic       done_res;
		logic       busy_res;
		logic       drive_low;
	} owm_result_t;

endpackage

@@ rtl/owm_engine.sv @@
// bus timing state machine: slot phases, microsecond prescaler, bit shifter
module owm_engine (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  owm_pkg::owm_item_t            item,
	input  logic [owm_pkg::CPM_W-1:0]     cpm,
	output owm_pkg::owm_result_t          result
);

	localparam logic [2:0] PH_IDLE     = 3'd0;
	localparam logic [2:0] PH_RST_LOW  = 3'd1;
	localparam logic [2:0] PH_RST_WAIT = 3'd2;
	localparam logic [2:0] PH_RST_REC  = 3'd3;
	localparam logic [2:0] PH_WR_LOW   = 3'd4;
	localparam logic [2:0] PH_WR_REL   = 3'd5;
	localparam logic [2:0] PH_RD_LOW   = 3'd6;
	localparam logic [2:0] PH_RD_REL   = 3'd7;

	logic [2:0] phase_q, phase_d;
	logic [owm_pkg::CPM_W-1:0] pre_q, pre_d;
	logic [owm_pkg::US_W-1:0] us_q, us_d, us_inc, len;
	logic [2:0] bitpos_q, bitpos_d;
	logic [7:0] shift_q, shift_d;
	logic pres_q, pres_d;
	logic done, pres_o, rej;
	logic [7:0] rbyte;

	always_comb begin
		unique case (phase_q)
			PH_RST_LOW:  len = owm_pkg::RESET_LOW_US;
			PH_RST_WAIT: len = owm_pkg::PRESENCE_SAMPLE_US;
			PH_RST_REC:  len = owm_pkg::RESET_RECOVERY_US;
			PH_WR_LOW:   len = shift_q[0] ? owm_pkg::WR_SHORT_US : owm_pkg::SLOT_US;
			PH_WR_REL:   len = shift_q[0] ? owm_pkg::SLOT_US : owm_pkg::WR_SHORT_US;
			PH_RD_LOW:   len = owm_pkg::RD_LOW_US;
			default:     len = owm_pkg::SLOT_US;
		endcase
	end

	assign us_inc = us_q + 9'd1;

	always_comb begin
		phase_d = phase_q;
		pre_d = pre_q;
		us_d = us_q;
		bitpos_d = bitpos_q;
		shift_d = shift_q;
		pres_d = pres_q;
		done = 1'b0;
		pres_o = 1'b0;
		rej = 1'b0;
		rbyte = 8'd0;
		if (item.kind != owm_pkg::KIND_TICK) begin
			if (phase_q != PH_IDLE) begin
				rej = 1'b1;
			end else begin
				bitpos_d = 3'd0;
				pre_d = '0;
				us_d = '0;
				unique case (item.kind)
					owm_pkg::KIND_RESET: begin
						pres_d = 1'b0;
						phase_d = PH_RST_LOW;
					end
					owm_pkg::KIND_WRITE: begin
						shift_d = item.write_byte;
						phase_d = PH_WR_LOW;
					end
					default: begin
						shift_d = 8'd0;
						phase_d = PH_RD_LOW;
					end
				endcase
			end
		end else if (phase_q != PH_IDLE) begin
			// first tick after release in a read slot samples the line
			if (phase_q == PH_RD_REL && us_q == '0 && pre_q == '0) begin
				shift_d = {item.line_level, shift_q[7:1]};
			end
			if ({1'b0, pre_q} + 9'd1 >= {1'b0, cpm}) begin
				pre_d = '0;
				us_d = us_inc;
				if (us_inc >= len) begin
					us_d = '0;
					unique case (phase_q)
						PH_RST_LOW: phase_d = PH_RST_WAIT;
						PH_RST_WAIT: begin
							pres_d = ~item.line_level;
							phase_d = PH_RST_REC;
						end
						PH_RST_REC: begin
							phase_d = PH_IDLE;
							done = 1'b1;
							pres_o = pres_q;
						end
						PH_WR_LOW: phase_d = PH_WR_REL;
						PH_WR_REL: begin
							shift_d = {1'b0, shift_q[7:1]};
							if (bitpos_q == 3'd7) begin
								bitpos_d = 3'd0;
								phase_d = PH_IDLE;
								done = 1'b1;
							end else begin
								bitpos_d = bitpos_q + 3'd1;
								phase_d = PH_WR_LOW;
							end
						end
						PH_RD_LOW: phase_d = PH_RD_REL;
						default: begin
							if (bitpos_q == 3'd7) begin
								bitpos_d = 3'd0;
								phase_d = PH_IDLE;
								done = 1'b1;
								rbyte = shift_d;
							end else begin
								bitpos_d = bitpos_q + 3'd1;
								phase_d = PH_RD_LOW;
							end
						end
					endcase
				end
			end else begin
				pre_d = pre_q + 8'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pre_q <= '0;
			us_q <= '0;
			bitpos_q <= 3'd0;
			shift_q <= 8'd0;
			pres_q <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			pre_q <= pre_d;
			us_q <= us_d;
			bitpos_q <= bitpos_d;
			shift_q <= shift_d;
			pres_q <= pres_d;
		end
	end

	always_comb begin
		result.drive_low = (phase_d == PH_RST_LOW) || (phase_d == PH_WR_LOW)
			|| (phase_d == PH_RD_LOW);
		result.busy_res = (phase_d != PH_IDLE);
		result.done_res = done;
		result.presence = pres_o;
		result.read_byte = rbyte;
		result.rejected = rej;
	end

	// bit counter only moves inside byte slots
	a_bitpos_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(bitpos_q != 3'd0) |-> (phase_q == PH_WR_LOW || phase_q == PH_WR_REL
			|| phase_q == PH_RD_LOW || phase_q == PH_RD_REL))
		else $error("bit position set outside a byte slot");

	// microsecond count never reaches the slot length without leaving it
	a_us_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_IDLE) |-> (us_q < len))
		else $error("microsecond count past phase length");

	// idle block holds the prescaler and the microsecond count cleared
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) |-> (pre_q == '0 && us_q == '0))
		else $error("timers running while idle");

endmodule

@@ rtl/one_wire_bus_master.sv @@
// one-wire bus master top level: input register, timing engine, result register
// an accepted word is held in the input register, its result word in the result register
// throughput: one word per cycle, limited only by m_tready back-pressure
// every bus slot is timed from tick words, cycles_per_microsecond ticks per us
// reset clears the bus phase and timers and sets cycles_per_microsecond to 168
// the line is released and no word is pending after reset
module one_wire_bus_master (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // write_byte[7:0], line_level[8], zero [15:9]
	input  logic [1:0]  s_tuser,  // kind[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // drive_low[0], busy_res[1], done_res[2], presence[3],
	                              // read_byte[11:4], rejected[12], zero [15:13]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);

	logic valid_s1;
	owm_pkg::owm_item_t item_s1;
	logic valid_s2;
	owm_pkg::owm_result_t res_s2;
	owm_pkg::owm_result_t res;
	logic [owm_pkg::CPM_W-1:0] cpm_q;
	logic out_free, advance;

	assign out_free = !valid_s2 || m_tready;
	assign advance = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpm_q <= owm_pkg::CPM_RESET;
		end else if (cfg_valid) begin
			cpm_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.kind <= s_tuser;
			item_s1.write_byte <= s_tdata[7:0];
			item_s1.line_level <= s_tdata[8];
		end
	end

	owm_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cpm    (cpm_q),
		.result (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata = {3'b000, res_s2.rejected, res_s2.read_byte, res_s2.presence,
		res_s2.done_res, res_s2.busy_res, res_s2.drive_low};

	// a finished operation leaves the block idle and released
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.done_res) |-> (!res_s2.busy_res && !res_s2.drive_low))
		else $error("done reported while still busy");

	// a rejected command never completes anything
	a_rej_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.rejected) |-> (res_s2.busy_res && !res_s2.done_res))
		else $error("rejected word not busy");

	// presence and read data only appear with done
	a_payload_done: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && (res_s2.presence || res_s2.read_byte != 8'd0)) |-> res_s2.done_res)
		else $error("result data without done");

endmodule

@@ bench/owm_checker.sv @@
`timescale 1ns / 1ps
// result checker for the one-wire bus master: bus timing predictor and word compare
module owm_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,  // write_byte[7:0], line_level[8], zero [15:9]
	input  logic [1:0]  s_tuser,  // kind[1:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,  // drive_low[0], busy_res[1], done_res[2], presence[3],
	                              // read_byte[11:4], rejected[12], zero [15:13]
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [7:0]  cfg_data,
	output int          fail_count,
	output int          pending,
	output int          words_checked,
	output int          ops_done,
	output int          cmds_rejected
);

	typedef enum logic [2:0] {
		BUS_IDLE, RST_LOW, RST_WAIT, RST_REC, WR_LOW, WR_REL, RD_LOW, RD_REL
	} bus_phase_t;

	localparam int REPORT_MAX = 10;

	bus_phase_t                ph;
	logic [owm_pkg::CPM_W-1:0] rate;
	logic [7:0]                prescale;
	logic [owm_pkg::US_W-1:0]  us_cnt;
	logic [2:0]                bit_pos;
	logic [7:0]                shreg;
	logic                      heard;

	owm_pkg::owm_result_t expected_q[$];
	owm_pkg::owm_result_t got;
	owm_pkg::owm_result_t want;
	owm_pkg::owm_item_t   w;
	int                   misses;
	int                   checked;
	int                   finished;
	int                   refused;

	// length in microseconds of the current bus phase
	function automatic logic [owm_pkg::US_W-1:0] slot_length();
		case (ph)
			RST_LOW:  return owm_pkg::RESET_LOW_US;
			RST_WAIT: return owm_pkg::PRESENCE_SAMPLE_US;
			RST_REC:  return owm_pkg::RESET_RECOVERY_US;
			WR_LOW:   return shreg[0] ? owm_pkg::WR_SHORT_US : owm_pkg::SLOT_US;
			WR_REL:   return shreg[0] ? owm_pkg::SLOT_US : owm_pkg::WR_SHORT_US;
			RD_LOW:   return owm_pkg::RD_LOW_US;
			default:  return owm_pkg::SLOT_US;
		endcase
	endfunction

	function automatic void go_phase(input bus_phase_t nx);
		ph = nx;
		prescale = '0;
		us_cnt = '0;
	endfunction

	function automatic owm_pkg::owm_result_t bus_step(input owm_pkg::owm_item_t it);
		owm_pkg::owm_result_t r;
		r = '0;
		if (it.kind != owm_pkg::KIND_TICK) begin
			if (ph != BUS_IDLE) begin
				r.rejected = 1'b1;
			end else begin
				bit_pos = '0;
				case (it.kind)
					owm_pkg::KIND_RESET: begin
						heard = 1'b0;
						go_phase(RST_LOW);
					end
					owm_pkg::KIND_WRITE: begin
						shreg = it.write_byte;
						go_phase(WR_LOW);
					end
					default: begin
						shreg = '0;
						go_phase(RD_LOW);
					end
				endcase
			end
		end else if (ph != BUS_IDLE) begin
			// read slots sample the line on the very first tick after release
			if (ph == RD_REL && us_cnt == 0 && prescale == 0)
				shreg = {it.line_level, shreg[7:1]};
			if (int'(prescale) + 1 >= int'(rate)) begin
				prescale = '0;
				us_cnt = us_cnt + 1'b1;
				if (us_cnt >= slot_length()) begin
					case (ph)
						RST_LOW: go_phase(RST_WAIT);
						RST_WAIT: begin
							heard = !it.line_level;
							go_phase(RST_REC);
						end
						RST_REC: begin
							go_phase(BUS_IDLE);
							r.done_res = 1'b1;
							r.presence = heard;
						end
						WR_LOW: go_phase(WR_REL);
						WR_REL: begin
							shreg = shreg >> 1;
							if (bit_pos == 3'd7) begin
								bit_pos = '0;
								go_phase(BUS_IDLE);
								r.done_res = 1'b1;
							end else begin
								bit_pos = bit_pos + 1'b1;
								go_phase(WR_LOW);
							end
						end
						RD_LOW: go_phase(RD_REL);
						default: begin
							if (bit_pos == 3'd7) begin
								bit_pos = '0;
								go_phase(BUS_IDLE);
								r.done_res = 1'b1;
								r.read_byte = shreg;
							end else begin
								bit_pos = bit_pos + 1'b1;
								go_phase(RD_LOW);
							end
						end
					endcase
				end
			end else begin
				prescale = prescale + 1'b1;
			end
		end
		r.drive_low = (ph == RST_LOW || ph == WR_LOW || ph == RD_LOW);
		r.busy_res = (ph != BUS_IDLE);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph = BUS_IDLE;
			rate = owm_pkg::CPM_RESET;
			prescale = '0;
			us_cnt = '0;
			bit_pos = '0;
			shreg = '0;
			heard = 1'b0;
			expected_q.delete();
			misses = 0;
			checked = 0;
			finished = 0;
			refused = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				rate = cfg_data;
			if (m_tvalid && m_tready) begin
				got = m_tdata[12:0];
				if (expected_q.size() == 0) begin
					misses++;
					if (misses <= REPORT_MAX)
						$display("result word %h arrived with nothing predicted", m_tdata);
				end else begin
					want = expected_q.pop_front();
					checked++;
					if (got.drive_low !== want.drive_low || got.busy_res !== want.busy_res ||
					    got.done_res !== want.done_res || got.presence !== want.presence ||
					    got.read_byte !== want.read_byte || got.rejected !== want.rejected ||
					    m_tdata[15:13] !== 3'b000) begin
						misses++;
						if (misses <= REPORT_MAX)
							$display({"word %0d mismatch: expected drv=%b busy=%b done=%b ",
								"pres=%b byte=%h rej=%b, got drv=%b busy=%b done=%b ",
								"pres=%b byte=%h rej=%b pad=%b"}, checked,
								want.drive_low, want.busy_res, want.done_res, want.presence,
								want.read_byte, want.rejected, got.drive_low, got.busy_res,
								got.done_res, got.presence, got.read_byte, got.rejected,
								m_tdata[15:13]);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				w.kind = s_tuser;
				w.write_byte = s_tdata[7:0];
				w.line_level = s_tdata[8];
				want = bus_step(w);
				if (want.done_res)
					finished++;
				if (want.rejected)
					refused++;
				expected_q.push_back(want);
			end
		end
		fail_count <= misses;
		pending <= expected_q.size();
		words_checked <= checked;
		ops_done <= finished;
		cmds_rejected <= refused;
	end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// testbench top for the one-wire bus master: clock, reset, stimulus and verdict
module tb;

	localparam int CYCLE_LIMIT = 100_000;
	localparam int DRAIN_CYCLES = 4;
	localparam int LONG_HOLD = 300;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;  // write_byte[7:0], line_level[8], zero [15:9]
	logic [1:0]  s_tuser = owm_pkg::KIND_TICK;  // kind[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;  // drive_low[0], busy_res[1], done_res[2], presence[3],
	                       // read_byte[11:4], rejected[12], zero [15:13]
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data = '0;

	logic        fast = 1'b0;  // no gaps or stalls on either side
	logic        hold_go = 1'b0;
	logic        hold_on = 1'b0;
	int          stall_left = 0;
	int          rx_gap;
	int unsigned cycle_cnt = 0;
	logic [7:0]  rate_now = owm_pkg::CPM_RESET;

	int fail_count;
	int pending;
	int words_checked;
	int ops_done;
	int cmds_rejected;

	one_wire_bus_master i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	owm_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending       (pending),
		.words_checked (words_checked),
		.ops_done      (ops_done),
		.cmds_rejected (cmds_rejected)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still expected", cycle_cnt, pending);
			$display("FAIL one_wire_bus_master");
			$finish;
		end
	end

	// result side: random stall after each word, plus one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left <= 0;
		end else if (hold_on) begin
			m_tready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_tready <= (stall_left == 1);
		end else if (m_tvalid && m_tready && !fast) begin
			rx_gap = $urandom_range(3);
			stall_left <= rx_gap;
			m_tready <= (rx_gap == 0);
		end else begin
			m_tready <= 1'b1;
		end
	end

	initial begin
		wait (hold_go);
		@(posedge clk);
		hold_on <= 1'b1;
		repeat (LONG_HOLD) @(posedge clk);
		hold_on <= 1'b0;
	end

	function automatic logic pick_level(input int mode);
		case (mode)
			0: return 1'b0;
			1: return 1'b1;
			default: return 1'($urandom_range(1));
		endcase
	endfunction

	// ticks a full operation needs at the current rate
	function automatic int ticks_for(input logic [1:0] k);
		int cp;
		cp = (rate_now == 0) ? 1 : int'(rate_now);
		case (k)
			owm_pkg::KIND_RESET:
				return cp * (int'(owm_pkg::RESET_LOW_US) + int'(owm_pkg::PRESENCE_SAMPLE_US) +
					int'(owm_pkg::RESET_RECOVERY_US));
			owm_pkg::KIND_WRITE:
				return cp * 8 * (int'(owm_pkg::SLOT_US) + int'(owm_pkg::WR_SHORT_US));
			default: return cp * 8 * (int'(owm_pkg::SLOT_US) + int'(owm_pkg::RD_LOW_US));
		endcase
	endfunction

	task automatic put_word(input logic [1:0] k, input logic [7:0] b, input logic lv);
		int gap;
		gap = fast ? 0 : $urandom_range(3);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= k;
		s_tdata <= {7'd0, lv, b};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// tick words, with the odd command thrown in while the bus is busy
	task automatic tick_run(input int n, input int mode, input bit noisy);
		for (int i = 0; i < n; i++) begin
			if (noisy && $urandom_range(63) == 0)
				put_word(2'($urandom_range(3, 1)), 8'($urandom), pick_level(2));
			put_word(owm_pkg::KIND_TICK, 8'($urandom), pick_level(mode));
		end
	endtask

	task automatic run_op(input logic [1:0] k, input logic [7:0] b, input int mode,
		input int short_by);
		put_word(k, b, pick_level(2));
		tick_run(ticks_for(k) - short_by, mode, 1'b1);
		tick_run($urandom_range(3), 2, 1'b0);
	endtask

	task automatic write_rate(input logic [7:0] v);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		rate_now = v;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset rate: idle ticks, a write with commands refused while it runs
		put_word(owm_pkg::KIND_TICK, 8'hFF, 1'b1);
		put_word(owm_pkg::KIND_TICK, 8'h00, 1'b0);
		put_word(owm_pkg::KIND_WRITE, 8'h96, 1'b0);
		put_word(owm_pkg::KIND_READ, 8'h00, 1'b0);
		put_word(owm_pkg::KIND_RESET, 8'h00, 1'b1);
		put_word(owm_pkg::KIND_WRITE, 8'hFF, 1'b1);
		tick_run(200, 2, 1'b0);

		// switch to one tick per microsecond in the middle of that write
		write_rate(8'd1);
		tick_run(480, 2, 1'b1);
		tick_run(12, 2, 1'b0);

		// zero rate acts as one, full read under a long result hold-off
		write_rate(8'd0);
		hold_go = 1'b1;
		run_op(owm_pkg::KIND_READ, 8'h00, 2, 0);

		// slowest rate, back to back: a reset that is still running at the end
		write_rate(8'd255);
		fast = 1'b1;
		put_word(owm_pkg::KIND_RESET, 8'h00, 1'b0);
		tick_run(60, 2, 1'b1);
		fast = 1'b0;

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("byte write across rates 168 and 1, byte read at rate 0 with a long stall,");
		$display("reset begun at rate 255: %0d words checked, %0d ops done, %0d refused, %0d bad",
			words_checked, ops_done, cmds_rejected, fail_count);
		if (fail_count == 0)
			$display("PASS one_wire_bus_master");
		else
			$display("FAIL one_wire_bus_master");
		$finish;
	end

endmodule

@@ files.f @@
rtl/owm_pkg.sv
rtl/owm_engine.sv
rtl/one_wire_bus_master.sv
bench/owm_checker.sv
bench/tb.sv
